### rtl/core/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared constants for the Cartesian to spherical converter
// Default widths, CORDIC stage count, guard bits, gain and arctangent table.
// ----------------------------------------------------------------------------
package c2s_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 24;

    // CORDIC iterations per vectoring pass and guard bits on magnitudes
    localparam int NSTAGES = 32;
    localparam int GUARD   = 24;

    // CORDIC gain K in Q30
    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

    // Angle accumulator scale: 2^32 per turn
    localparam longint QUARTER32 = 64'sd1073741824;
    localparam longint HALF32    = 64'sd2147483648;
    localparam longint TURN32    = 64'sd4294967296;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical: pipelined 3-D vector to radius, azimuth, elevation
// Two unrolled CORDIC vectoring passes and a bit-per-stage square root.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)              tuser    transfer
//  s_axis    in   x_coord, y_coord, z_coord              -        tvalid & tready
//  m_axis    out  radius, azimuth, elevation             status   tvalid & tready
//
//  One vector per cycle while m_axis is not stalled. The pipeline is the input
//  register, the two 32-stage CORDIC passes with their setup stages and the
//  output register. The square root runs alongside the azimuth pass.
//  Reset clears only the valid bits. A stall on m_axis freezes the whole
//  pipeline; s_axis tready is high whenever the output register is free
//  or being taken.
// ----------------------------------------------------------------------------
module cartesian_to_spherical
    import c2s_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // x_coord, y_coord, z_coord, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // radius, azimuth, elevation, zero fill
    output logic [((COORD_BITS+2*ANGLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // status
    output logic                 o_m_axis_tuser
);

    localparam int C      = COORD_BITS;
    localparam int AB     = ANGLE_BITS;
    localparam int W      = C + GUARD + 4;
    localparam int AW     = 35;
    localparam int OUT_W  = ((C + 2*AB + 7) / 8) * 8;
    localparam int SHR    = 32 - AB;
    localparam int P1_END = NSTAGES + 1;       // last azimuth iteration stage
    localparam int AZ_FIN = NSTAGES + 2;       // azimuth finish, elevation setup
    localparam int L      = 2 * NSTAGES + 2;   // last pipeline stage

    typedef struct packed {
        logic                 sx;
        logic                 sy;
        logic                 sz;
        logic                 zx;
        logic                 zy;
        logic                 zz;
        logic [C-1:0]         mx;
        logic [C-1:0]         my;
        logic [C-1:0]         mz;
        logic [2*C-1:0]       sqx;
        logic [2*C-1:0]       sqy;
        logic [2*C-1:0]       sqz;
        logic [2*C:0]         rem;
        logic [C-1:0]         root;
        logic signed [W-1:0]  a;
        logic signed [W-1:0]  b;
        logic signed [W-1:0]  zk;
        logic signed [AW-1:0] ang;
        logic [AB-1:0]        azi;
    } t_stage;

    t_stage        r_st [0:L];
    t_stage        n_st [0:L];
    logic [L:0]    r_vld;
    logic          w_en;

    logic [C-1:0]  r_rad;
    logic [AB-1:0] r_azi;
    logic [AB-1:0] r_ele;
    logic          r_stat;
    logic          r_out_vld;
    logic [C-1:0]  n_rad;
    logic [AB-1:0] n_azi;
    logic [AB-1:0] n_ele;
    logic          n_stat;

    logic [C-1:0]  w_x;
    logic [C-1:0]  w_y;
    logic [C-1:0]  w_z;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    assign w_x = i_s_axis_tdata[C-1:0];
    assign w_y = i_s_axis_tdata[2*C-1:C];
    assign w_z = i_s_axis_tdata[3*C-1:2*C];

    // Input stage: signs, magnitudes, zero flags
    always_comb begin
        n_st[0]     = r_st[0];
        n_st[0].sx  = w_x[C-1];
        n_st[0].sy  = w_y[C-1];
        n_st[0].sz  = w_z[C-1];
        n_st[0].mx  = w_x[C-1] ? (~w_x + C'(1)) : w_x;
        n_st[0].my  = w_y[C-1] ? (~w_y + C'(1)) : w_y;
        n_st[0].mz  = w_z[C-1] ? (~w_z + C'(1)) : w_z;
        n_st[0].zx  = (w_x == '0);
        n_st[0].zy  = (w_y == '0);
        n_st[0].zz  = (w_z == '0);
    end

    genvar k;
    generate
        for (k = 1; k <= L; k++) begin : g_stage
            localparam bit DO_CORDIC = (k >= 2 && k <= P1_END) || (k > AZ_FIN);
            localparam int SH        = (k <= P1_END) ? ((k >= 2) ? k - 2 : 0)
                                                     : ((k > AZ_FIN) ? k - AZ_FIN - 1 : 0);
            localparam bit DO_SQRT   = (k >= 3) && (k <= C + 2);
            localparam int SP        = DO_SQRT ? (C + 2 - k) : 0;

            logic [C+30:0]        w_prod;
            logic signed [W-1:0]  w_babs;
            logic [2*C:0]         w_trial;
            logic signed [AW-1:0] w_th;
            logic signed [AW-1:0] w_q;
            logic [AW-1:0]        w_rnd;

            always_comb begin
                n_st[k] = r_st[k-1];
                w_prod  = (C+31)'(r_st[k-1].mz) * (C+31)'(GAIN_Q30);
                w_babs  = r_st[k-1].b[W-1] ? -r_st[k-1].b : r_st[k-1].b;
                w_trial = (2*C+1)'({r_st[k-1].root, 2'b01}) << (2 * SP);
                w_q     = AW'(QUARTER32);

                // clamp accumulated angle to [0, quarter]
                if (r_st[k-1].ang[AW-1]) begin
                    w_th = '0;
                end else if (r_st[k-1].ang > w_q) begin
                    w_th = w_q;
                end else begin
                    w_th = r_st[k-1].ang;
                end

                if (k == 1) begin
                    n_st[k].sqx = (2*C)'(r_st[k-1].mx) * (2*C)'(r_st[k-1].mx);
                    n_st[k].sqy = (2*C)'(r_st[k-1].my) * (2*C)'(r_st[k-1].my);
                    n_st[k].sqz = (2*C)'(r_st[k-1].mz) * (2*C)'(r_st[k-1].mz);
                    n_st[k].a   = W'(r_st[k-1].mx) <<< GUARD;
                    n_st[k].b   = W'(r_st[k-1].my) <<< GUARD;
                    n_st[k].ang = '0;
                    n_st[k].zk  = W'(w_prod >> (30 - GUARD));
                end

                if (k == 2) begin
                    n_st[k].rem  = (2*C+1)'(r_st[k-1].sqx) + (2*C+1)'(r_st[k-1].sqy)
                                 + (2*C+1)'(r_st[k-1].sqz);
                    n_st[k].root = '0;
                end

                if (DO_SQRT) begin
                    if (r_st[k-1].rem >= w_trial) begin
                        n_st[k].rem  = r_st[k-1].rem - w_trial;
                        n_st[k].root = {r_st[k-1].root[C-2:0], 1'b1};
                    end else begin
                        n_st[k].root = {r_st[k-1].root[C-2:0], 1'b0};
                    end
                end

                if (DO_CORDIC) begin
                    n_st[k].a = r_st[k-1].a + (w_babs >>> SH);
                    if (!r_st[k-1].b[W-1]) begin
                        n_st[k].b   = r_st[k-1].b - (r_st[k-1].a >>> SH);
                        n_st[k].ang = r_st[k-1].ang + AW'(atan_val(SH));
                    end else begin
                        n_st[k].b   = r_st[k-1].b + (r_st[k-1].a >>> SH);
                        n_st[k].ang = r_st[k-1].ang - AW'(atan_val(SH));
                    end
                end

                if (k == AZ_FIN) begin
                    // fold the first-quadrant angle into the full turn
                    if (r_st[k-1].zy) begin
                        w_th = '0;
                    end
                    if (r_st[k-1].zx) begin
                        w_th = w_q;
                    end
                    case ({r_st[k-1].sx, r_st[k-1].sy})
                        2'b00:   w_th = w_th;
                        2'b10:   w_th = AW'(HALF32) - w_th;
                        2'b11:   w_th = AW'(HALF32) + w_th;
                        default: w_th = AW'(TURN32) - w_th;
                    endcase
                    w_rnd       = (AW'(w_th) + ((AW'(1) << SHR) >> 1)) >> SHR;
                    n_st[k].azi = AB'(w_rnd);
                    n_st[k].b   = r_st[k-1].zk;
                    n_st[k].ang = '0;
                end else begin
                    w_rnd = (AW'(w_th) + ((AW'(1) << SHR) >> 1)) >> SHR;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0] <= n_st[0];
        end
    end

    // Output stage: elevation rounding and the special cases
    logic signed [AW-1:0] w_eth;
    logic [AW-1:0]        w_e;
    logic [AW-1:0]        w_quarter;

    assign w_quarter = AW'(1) << (AB - 2);

    // clamp the elevation angle of the last stage to [0, quarter]
    always_comb begin
        if (r_st[L].ang[AW-1]) begin
            w_eth = '0;
        end else if (r_st[L].ang > $signed(AW'(QUARTER32))) begin
            w_eth = $signed(AW'(QUARTER32));
        end else begin
            w_eth = r_st[L].ang;
        end
    end

    assign w_e = (AW'(w_eth) + ((AW'(1) << SHR) >> 1)) >> SHR;

    always_comb begin
        n_rad  = r_st[L].root;
        n_azi  = r_st[L].azi;
        n_stat = 1'b0;
        if (r_st[L].zz) begin
            n_ele = '0;
        end else if (w_e > w_quarter) begin
            n_ele = r_st[L].sz ? -AB'(w_quarter) : AB'(w_quarter);
        end else begin
            n_ele = r_st[L].sz ? -AB'(w_e) : AB'(w_e);
        end
        if (r_st[L].zx && r_st[L].zy) begin
            n_azi = '0;
            n_ele = r_st[L].sz ? -AB'(w_quarter) : AB'(w_quarter);
            if (r_st[L].zz) begin
                n_rad  = '0;
                n_ele  = '0;
                n_stat = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[L-1:0], i_s_axis_tvalid};
            r_out_vld <= r_vld[L];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad  <= n_rad;
            r_azi  <= n_azi;
            r_ele  <= n_ele;
            r_stat <= n_stat;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'({r_ele, r_azi, r_rad});
    assign o_m_axis_tuser  = r_stat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_zero_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (r_rad == '0 && r_azi == '0 && r_ele == '0))
        else $error("zero-vector result carries nonzero data");

    a_ele_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(r_ele) <= $signed(AB'(w_quarter)) &&
                             $signed(r_ele) >= -$signed(AB'(w_quarter))))
        else $error("elevation outside a quarter turn");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_axis_tready && r_vld[L]) |=> o_m_axis_tvalid)
        else $error("pipeline tail lost a transfer");

endmodule
